// ===== src/sha1fpm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 prefix match package
// Round counts, round constants, boolean-function tables and register
// indexes shared by the SHA-1 final-block prefix match core.
// ----------------------------------------------------------------------------
package sha1fpm_pkg;

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned WIN_WORDS  = 16;
    localparam int unsigned MSG_WORDS  = 12;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 64;

    // Truth tables of the round functions, indexed by {b, c, d}.
    localparam logic [7:0] CH_LUT  = 8'hCA;
    localparam logic [7:0] PAR_LUT = 8'h96;
    localparam logic [7:0] MAJ_LUT = 8'hE8;

    localparam logic [31:0] RK0 = 32'h5A827999;
    localparam logic [31:0] RK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK3 = 32'hCA62C1D6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIDSTATE_AB   = 4'd0,
        CFG_MIDSTATE_CD   = 4'd1,
        CFG_MIDSTATE_E    = 4'd2,
        CFG_TAIL_LO       = 4'd3,
        CFG_TAIL_HI       = 4'd4,
        CFG_PREFIX_MASK   = 4'd5,
        CFG_PREFIX_TARGET = 4'd6,
        CFG_CHECK_SECOND  = 4'd7
    } t_cfg_idx;

    function automatic logic [31:0] round_const(input int unsigned rnd);
        logic [31:0] k;
        if (rnd < 20)      k = RK0;
        else if (rnd < 40) k = RK1;
        else if (rnd < 60) k = RK2;
        else               k = RK3;
        return k;
    endfunction

    function automatic logic [7:0] round_lut(input int unsigned rnd);
        logic [7:0] lut;
        if (rnd < 20)      lut = CH_LUT;
        else if (rnd < 40) lut = PAR_LUT;
        else if (rnd < 60) lut = MAJ_LUT;
        else               lut = PAR_LUT;
        return lut;
    endfunction

endpackage
`default_nettype wire

// ===== src/sha1_final_block_prefix_match_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 final-block prefix match core
// Runs the 80-round SHA-1 compression of one final block per candidate item,
// adds the configured midstate and flags a masked prefix match.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  -------------------------
//  in        sink       i_in_valid / o_in_stall     i_msg_word_0 .. _11
//  out       source     o_out_valid / i_out_stall   o_hit, o_digest_0 .. _4
//  cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item is accepted every cycle unless the sink stalls a finished item. An
// item passes one load stage, one stage per SHA-1 round (80), and one stage
// for the midstate addition on its way to the output register; the hit
// compare sits in front of the output register. Reset is synchronous, active
// low; it clears the valid bits and the configuration registers. When the output
// register holds an item that the sink stalls, the whole pipeline freezes
// and the input is stalled in the same cycle, so nothing is lost or repeated.
//
module sha1_final_block_prefix_match_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Candidate input channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [31:0]                         i_msg_word_0,
    input  wire logic [31:0]                         i_msg_word_1,
    input  wire logic [31:0]                         i_msg_word_2,
    input  wire logic [31:0]                         i_msg_word_3,
    input  wire logic [31:0]                         i_msg_word_4,
    input  wire logic [31:0]                         i_msg_word_5,
    input  wire logic [31:0]                         i_msg_word_6,
    input  wire logic [31:0]                         i_msg_word_7,
    input  wire logic [31:0]                         i_msg_word_8,
    input  wire logic [31:0]                         i_msg_word_9,
    input  wire logic [31:0]                         i_msg_word_10,
    input  wire logic [31:0]                         i_msg_word_11,
    // Result output channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_hit,
    output logic [31:0]                              o_digest_0,
    output logic [31:0]                              o_digest_1,
    output logic [31:0]                              o_digest_2,
    output logic [31:0]                              o_digest_3,
    output logic [31:0]                              o_digest_4,
    // Configuration write channel.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sha1fpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sha1fpm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sha1fpm_pkg::*;

    // Configuration registers.
    logic [63:0] r_mid_ab;
    logic [63:0] r_mid_cd;
    logic [31:0] r_mid_e;
    logic [63:0] r_tail_lo;
    logic [63:0] r_tail_hi;
    logic [63:0] r_mask;
    logic [63:0] r_target;
    logic        r_chk2;

    // Round pipeline. Stage j holds the working words after j rounds and the
    // message window W[j] .. W[j+15]; element 0 of the window is the word
    // that round j consumes.
    logic [NUM_ROUNDS:0] r_vld;
    logic [31:0]         r_a   [0:NUM_ROUNDS];
    logic [31:0]         r_b   [0:NUM_ROUNDS];
    logic [31:0]         r_c   [0:NUM_ROUNDS];
    logic [31:0]         r_d   [0:NUM_ROUNDS];
    logic [31:0]         r_e   [0:NUM_ROUNDS];
    logic [31:0]         r_win [0:NUM_ROUNDS][0:WIN_WORDS-1];

    // Midstate addition stage.
    logic        r_dig_vld;
    logic [31:0] r_dig [0:4];

    // Output register.
    logic        r_out_vld;
    logic        r_hit;
    logic [31:0] r_out [0:4];

    logic        w_en;
    logic        w_accept;
    logic        n_hit;

    // The pipeline moves unless a finished item waits on a stalled sink.
    assign w_en       = !(r_out_vld && i_out_stall);
    assign o_in_stall = !w_en;
    assign w_accept   = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes past the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_ab  <= '0;
            r_mid_cd  <= '0;
            r_mid_e   <= '0;
            r_tail_lo <= '0;
            r_tail_hi <= '0;
            r_mask    <= '0;
            r_target  <= '0;
            r_chk2    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIDSTATE_AB:   r_mid_ab  <= i_cfg_data;
                CFG_MIDSTATE_CD:   r_mid_cd  <= i_cfg_data;
                CFG_MIDSTATE_E:    r_mid_e   <= i_cfg_data[31:0];
                CFG_TAIL_LO:       r_tail_lo <= i_cfg_data;
                CFG_TAIL_HI:       r_tail_hi <= i_cfg_data;
                CFG_PREFIX_MASK:   r_mask    <= i_cfg_data;
                CFG_PREFIX_TARGET: r_target  <= i_cfg_data;
                CFG_CHECK_SECOND:  r_chk2    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Load stage: the candidate words join the fixed tail words, and the
    // working words start from the midstate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a[0]      <= r_mid_ab[63:32];
            r_b[0]      <= r_mid_ab[31:0];
            r_c[0]      <= r_mid_cd[63:32];
            r_d[0]      <= r_mid_cd[31:0];
            r_e[0]      <= r_mid_e;
            r_win[0][0]  <= i_msg_word_0;
            r_win[0][1]  <= i_msg_word_1;
            r_win[0][2]  <= i_msg_word_2;
            r_win[0][3]  <= i_msg_word_3;
            r_win[0][4]  <= i_msg_word_4;
            r_win[0][5]  <= i_msg_word_5;
            r_win[0][6]  <= i_msg_word_6;
            r_win[0][7]  <= i_msg_word_7;
            r_win[0][8]  <= i_msg_word_8;
            r_win[0][9]  <= i_msg_word_9;
            r_win[0][10] <= i_msg_word_10;
            r_win[0][11] <= i_msg_word_11;
            r_win[0][12] <= r_tail_lo[63:32];
            r_win[0][13] <= r_tail_lo[31:0];
            r_win[0][14] <= r_tail_hi[63:32];
            r_win[0][15] <= r_tail_hi[31:0];
        end
    end

    // One register stage per round.
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        localparam logic [7:0]  FLUT = round_lut(g);
        localparam logic [31:0] K    = round_const(g);

        logic [31:0] w_f;
        logic [31:0] w_t;
        logic [31:0] w_sched;
        logic [31:0] w_mix;

        // Bitwise round function, taken from its truth table.
        always_comb begin
            for (int k = 0; k < 32; k++) begin
                w_f[k] = FLUT[{r_b[g][k], r_c[g][k], r_d[g][k]}];
            end
        end

        assign w_t = {r_a[g][26:0], r_a[g][31:27]} + w_f + r_e[g] + K + r_win[g][0];

        // Next schedule word W[j+16]; the window shifts down by one word.
        assign w_mix   = r_win[g][13] ^ r_win[g][8] ^ r_win[g][2] ^ r_win[g][0];
        assign w_sched = {w_mix[30:0], w_mix[31]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (w_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_a[g+1] <= w_t;
                r_b[g+1] <= r_a[g];
                r_c[g+1] <= {r_b[g][1:0], r_b[g][31:2]};
                r_d[g+1] <= r_c[g];
                r_e[g+1] <= r_d[g];
                for (int k = 0; k < WIN_WORDS - 1; k++) begin
                    r_win[g+1][k] <= r_win[g][k+1];
                end
                r_win[g+1][WIN_WORDS-1] <= w_sched;
            end
        end
    end

    // Feed-forward addition of the midstate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig_vld <= 1'b0;
        end else if (w_en) begin
            r_dig_vld <= r_vld[NUM_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dig[0] <= r_a[NUM_ROUNDS] + r_mid_ab[63:32];
            r_dig[1] <= r_b[NUM_ROUNDS] + r_mid_ab[31:0];
            r_dig[2] <= r_c[NUM_ROUNDS] + r_mid_cd[63:32];
            r_dig[3] <= r_d[NUM_ROUNDS] + r_mid_cd[31:0];
            r_dig[4] <= r_e[NUM_ROUNDS] + r_mid_e;
        end
    end

    // Prefix compare: word 0 always, word 1 only when enabled.
    always_comb begin
        n_hit = ((r_dig[0] & r_mask[63:32]) == r_target[63:32]);
        if (r_chk2) begin
            n_hit = n_hit && ((r_dig[1] & r_mask[31:0]) == r_target[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dig_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= n_hit;
            for (int k = 0; k < 5; k++) begin
                r_out[k] <= r_dig[k];
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_hit       = r_hit;
    assign o_digest_0  = r_out[0];
    assign o_digest_1  = r_out[1];
    assign o_digest_2  = r_out[2];
    assign o_digest_3  = r_out[3];
    assign o_digest_4  = r_out[4];

`ifndef SYNTHESIS
    // An accepted item always lands in the load stage.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_vld[0])
        else $error("accepted item missing from load stage");

    // A frozen pipeline keeps the valid bits of the load, round and addition stages in place.
    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_vld) && $stable(r_dig_vld)))
        else $error("pipeline moved while frozen");

    // The last round stage reaches the output through the midstate addition stage when free.
    a_tail_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_ROUNDS] && w_en) |=> (r_dig_vld && w_en) |=> r_out_vld)
        else $error("item lost between round pipeline and output");

    // A reported hit agrees with the masked first digest word.
    a_hit_word0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |->
            ((o_digest_0 & r_mask[63:32]) == r_target[63:32]))
        else $error("hit flag disagrees with digest word 0");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 final-block prefix match core testbench
// Feeds candidate blocks and register writes into the core. A behavioral SHA-1
// compression predicts each digest and hit flag not given by hand, and each
// result leaving the core is compared word by word with the oldest expected
// one. A short scripted part with published SHA-1 vectors comes first. Random
// phases with fresh register settings and random idling on both sides follow.
// ----------------------------------------------------------------------------
module tb_top;
    import sha1fpm_pkg::*;

    localparam int unsigned PHASES         = 8;
    localparam int unsigned PHASE_ITEMS    = 160;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned CFG_NUM_REGS   = int'(CFG_CHECK_SECOND) + 1;
    localparam int unsigned CFG_IDX_TOP    = (1 << CFG_IDX_W) - 1;
    // An index that maps to no register: writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = CFG_IDX_W'(CFG_IDX_TOP);

    typedef logic [MSG_WORDS-1:0][31:0] t_candidate;

    typedef struct packed {
        logic             hit;
        logic [4:0][31:0] digest;
    } t_outcome;

    // Per accepted item: either a hand-typed answer or a request to predict.
    typedef struct {
        bit       known;
        t_outcome value;
    } t_answer;

    typedef enum {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        t_candidate            cand;
        bit                    known;
        t_outcome              want;
    } t_script_row;

    typedef enum {SETUP_RANDOM, SETUP_ZERO, SETUP_ONES} t_setup_flavor;

    // ------------------------------------------------------------------------
    // Signals. Every input of the core starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_candidate            cand_words  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_hit;
    logic [31:0]           o_digest_0;
    logic [31:0]           o_digest_1;
    logic [31:0]           o_digest_2;
    logic [31:0]           o_digest_3;
    logic [31:0]           o_digest_4;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Our own copy of the register file, as the core should hold it.
    logic [CFG_DATA_W-1:0] shadow_regs [CFG_NUM_REGS] = '{default: '0};
    t_answer               known_digests [$];
    t_outcome              pending_digests [$];
    int unsigned           digest_errors  = 0;
    int unsigned           quiet_cycles   = 0;
    int unsigned           src_gap_pct    = 0;
    int unsigned           sink_stall_pct = 0;
    int unsigned           sink_stall_left = 0;

    sha1_final_block_prefix_match_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_msg_word_0  (cand_words[0]),
        .i_msg_word_1  (cand_words[1]),
        .i_msg_word_2  (cand_words[2]),
        .i_msg_word_3  (cand_words[3]),
        .i_msg_word_4  (cand_words[4]),
        .i_msg_word_5  (cand_words[5]),
        .i_msg_word_6  (cand_words[6]),
        .i_msg_word_7  (cand_words[7]),
        .i_msg_word_8  (cand_words[8]),
        .i_msg_word_9  (cand_words[9]),
        .i_msg_word_10 (cand_words[10]),
        .i_msg_word_11 (cand_words[11]),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_digest_0    (o_digest_0),
        .o_digest_1    (o_digest_1),
        .o_digest_2    (o_digest_2),
        .o_digest_3    (o_digest_3),
        .o_digest_4    (o_digest_4),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Digest predictor: the full 80-round compression of the final block,
    // chained from the shadow midstate, followed by the masked prefix compare.
    // ------------------------------------------------------------------------
    function automatic t_outcome hash_candidate(input t_candidate cand);
        logic [31:0]           w [WIN_WORDS];
        logic [31:0]           mid [5];
        logic [31:0]           a, b, c, d, e, f, k, t, nw;
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] target;
        t_outcome              res;
        for (int i = 0; i < MSG_WORDS; i++)
            w[i] = cand[i];
        w[12]  = shadow_regs[CFG_TAIL_LO][63:32];
        w[13]  = shadow_regs[CFG_TAIL_LO][31:0];
        w[14]  = shadow_regs[CFG_TAIL_HI][63:32];
        w[15]  = shadow_regs[CFG_TAIL_HI][31:0];
        mid[0] = shadow_regs[CFG_MIDSTATE_AB][63:32];
        mid[1] = shadow_regs[CFG_MIDSTATE_AB][31:0];
        mid[2] = shadow_regs[CFG_MIDSTATE_CD][63:32];
        mid[3] = shadow_regs[CFG_MIDSTATE_CD][31:0];
        mid[4] = shadow_regs[CFG_MIDSTATE_E][31:0];
        {a, b, c, d, e} = {mid[0], mid[1], mid[2], mid[3], mid[4]};
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            if (r < WIN_WORDS) begin
                nw = w[r];
            end else begin
                // Message schedule kept in a 16-word circular window.
                nw = w[(r - 3) % WIN_WORDS] ^ w[(r - 8) % WIN_WORDS] ^
                     w[(r - 14) % WIN_WORDS] ^ w[r % WIN_WORDS];
                nw = {nw[30:0], nw[31]};
                w[r % WIN_WORDS] = nw;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = RK0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RK1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RK2;
            end else begin
                f = b ^ c ^ d;
                k = RK3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + nw;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        res.digest[0] = a + mid[0];
        res.digest[1] = b + mid[1];
        res.digest[2] = c + mid[2];
        res.digest[3] = d + mid[3];
        res.digest[4] = e + mid[4];
        mask   = shadow_regs[CFG_PREFIX_MASK];
        target = shadow_regs[CFG_PREFIX_TARGET];
        res.hit = (res.digest[0] & mask[63:32]) == target[63:32];
        if (shadow_regs[CFG_CHECK_SECOND][0])
            res.hit = res.hit && ((res.digest[1] & mask[31:0]) == target[31:0]);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the core's
    // outputs and our nonblocking-driven inputs still hold their pre-edge
    // values. Register writes update the shadow copy; an accepted candidate
    // queues its expected result; an accepted result is checked against the
    // oldest queued one.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : digest_monitor
        t_answer  key;
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            shadow_regs = '{default: '0};
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                // Midstate e and the compare enable keep only their width;
                // unmapped indexes change nothing.
                case (i_cfg_index)
                    CFG_MIDSTATE_E:   shadow_regs[i_cfg_index] = {32'h0, i_cfg_data[31:0]};
                    CFG_CHECK_SECOND: shadow_regs[i_cfg_index] = {63'h0, i_cfg_data[0]};
                    default: begin
                        if (i_cfg_index < CFG_NUM_REGS)
                            shadow_regs[i_cfg_index] = i_cfg_data;
                    end
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                key = known_digests.pop_front();
                if (key.known)
                    pending_digests.push_back(key.value);
                else
                    pending_digests.push_back(hash_candidate(cand_words));
            end
            if (o_out_valid && !i_out_stall) begin
                got.hit    = o_hit;
                got.digest = {o_digest_4, o_digest_3, o_digest_2, o_digest_1, o_digest_0};
                if (pending_digests.size() == 0) begin
                    $display("%0t: unexpected result, hit %0b digest %h", $time, got.hit,
                             got.digest);
                    digest_errors++;
                end else begin
                    want = pending_digests.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0b actual %0b", $time,
                                 want.hit, got.hit);
                        digest_errors++;
                    end
                    for (int j = 0; j < 5; j++) begin
                        if (got.digest[j] !== want.digest[j]) begin
                            $display("%0t: digest_%0d mismatch, expected %h actual %h",
                                     $time, j, want.digest[j], got.digest[j]);
                            digest_errors++;
                        end
                    end
                end
            end
        end
    end

    // Result sink: stalls come in bursts of random length at a rate set per
    // phase; a rate of zero gives a stretch with no stalls at all.
    always @(posedge i_clk) begin : result_sink
        if (sink_stall_left != 0) begin
            sink_stall_left <= sink_stall_left - 1;
            i_out_stall     <= 1'b1;
        end else if (sink_stall_pct != 0 && $urandom_range(99, 0) < sink_stall_pct) begin
            sink_stall_left <= $urandom_range(11, 0);
            i_out_stall     <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog: counts cycles in which no channel completes a handshake.
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Waits until every queued result has left the core. The candidate valid
    // is dropped first so the pipeline can empty.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_digests.size() != 0);
    endtask

    // Register writes only happen with the core empty. Valid is lowered
    // after the handshake, and the drain wait runs before the next write,
    // so valid is never lowered and raised at once.
    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Presents one candidate and holds it until accepted. Valid stays high
    // into the next candidate unless a gap burst is drawn.
    task automatic drive_candidate(input t_candidate cand, input bit known,
                                   input t_outcome want);
        known_digests.push_back('{known, want});
        i_in_valid <= 1'b1;
        cand_words <= cand;
        do @(posedge i_clk); while (o_in_stall);
        if (src_gap_pct != 0 && $urandom_range(99, 0) < src_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
    endtask

    function automatic t_candidate random_candidate();
        t_candidate cand;
        for (int i = 0; i < MSG_WORDS; i++) begin
            case ($urandom_range(9, 0))
                0:       cand[i] = '0;
                1:       cand[i] = '1;
                default: cand[i] = $urandom;
            endcase
        end
        return cand;
    endfunction

    // Masks are kept narrow most of the time so that hits are common.
    function automatic logic [31:0] random_mask_half();
        logic [31:0] m;
        case ($urandom_range(3, 0))
            0:       m = '0;
            1:       m = '1;
            2:       m = $urandom & $urandom & $urandom;
            default: m = ~(32'hFFFF_FFFF >> $urandom_range(8, 1));
        endcase
        return m;
    endfunction

    function automatic int unsigned random_idle_pct();
        int unsigned pct;
        case ($urandom_range(3, 0))
            0:       pct = 0;
            1:       pct = 5;
            2:       pct = 25;
            default: pct = 60;
        endcase
        return pct;
    endfunction

    // Writes every register for one random phase.
    task automatic program_phase(input t_setup_flavor flavor);
        logic [CFG_DATA_W-1:0] val;
        logic [CFG_DATA_W-1:0] mask_val;
        mask_val = '0;
        for (int r = 0; r < CFG_NUM_REGS; r++) begin
            case (flavor)
                SETUP_ZERO: val = '0;
                SETUP_ONES: val = '1;
                default: begin
                    val = {$urandom, $urandom};
                    if (r == CFG_PREFIX_MASK) begin
                        val      = {random_mask_half(), random_mask_half()};
                        mask_val = val;
                    end else if (r == CFG_PREFIX_TARGET && $urandom_range(5, 0) != 0) begin
                        // Usually reachable; otherwise bits outside the mask.
                        val = val & mask_val;
                    end
                end
            endcase
            write_register(CFG_IDX_W'(r), val);
        end
        if (flavor == SETUP_RANDOM && $urandom_range(1, 0) != 0)
            write_register(CFG_IDX_W'($urandom_range(CFG_IDX_TOP, CFG_NUM_REGS)),
                           {$urandom, $urandom});
    endtask

    // ------------------------------------------------------------------------
    // Scripted rows
    // ------------------------------------------------------------------------
    function automatic t_script_row write_row(input logic [CFG_IDX_W-1:0]  idx,
                                              input logic [CFG_DATA_W-1:0] data);
        t_script_row row;
        row       = '{kind: ROW_WRITE, default: '0};
        row.index = idx;
        row.data  = data;
        return row;
    endfunction

    function automatic t_script_row item_row(input t_candidate cand);
        t_script_row row;
        row      = '{kind: ROW_ITEM, default: '0};
        row.cand = cand;
        return row;
    endfunction

    function automatic t_script_row known_row(input t_candidate cand, input logic hit,
                                              input logic [4:0][31:0] digest);
        t_script_row row;
        row             = item_row(cand);
        row.known       = 1'b1;
        row.want.hit    = hit;
        row.want.digest = digest;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_script_row      script [$];
        t_candidate       empty_msg;
        t_candidate       abc_msg;
        logic [4:0][31:0] empty_digest;
        logic [4:0][31:0] abc_digest;
        t_outcome         unused;
        t_setup_flavor    flavor;

        unused    = '0;
        empty_msg = '0;
        abc_msg   = '0;
        // Padded one-block messages: the empty string and "abc". The length
        // word W15 comes from the tail register.
        empty_msg[0] = 32'h8000_0000;
        abc_msg[0]   = 32'h6162_6380;
        empty_digest = {32'hAFD8_0709, 32'h9560_1890, 32'h3255_BFEF, 32'h5E6B_4B0D,
                        32'hDA39_A3EE};
        abc_digest   = {32'h9CD0_D89D, 32'h7850_C26C, 32'hBA3E_2571, 32'h4706_816A,
                        32'hA999_3E36};

        // With every register at its reset value the mask is zero, so every
        // candidate hits; digests come from the predictor.
        script.push_back(item_row('0));
        script.push_back(item_row('1));
        script.push_back(item_row({6{32'h5555_5555, 32'hAAAA_AAAA}}));
        script.push_back(item_row({6{32'hAAAA_AAAA, 32'h5555_5555}}));
        // Standard SHA-1 initial value. Midstate e carries junk in its upper
        // half, which the core must drop. The unmapped write must be ignored.
        script.push_back(write_row(CFG_MIDSTATE_AB, 64'h6745_2301_EFCD_AB89));
        script.push_back(write_row(CFG_MIDSTATE_CD, 64'h98BA_DCFE_1032_5476));
        script.push_back(write_row(CFG_MIDSTATE_E, 64'hFFFF_FFFF_C3D2_E1F0));
        script.push_back(write_row(CFG_TAIL_LO, 64'h0));
        script.push_back(write_row(CFG_TAIL_HI, 64'h0));
        script.push_back(write_row(CFG_PREFIX_MASK, '1));
        script.push_back(write_row(CFG_PREFIX_TARGET, 64'hDA39_A3EE_5E6B_4B0D));
        script.push_back(write_row(CFG_CHECK_SECOND, 64'h8000_0000_0000_0003));
        script.push_back(write_row(CFG_IDX_UNMAPPED, '1));
        script.push_back(known_row(empty_msg, 1'b1, empty_digest));
        script.push_back(item_row(abc_msg));
        script.push_back(item_row('1));
        // Length of "abc" is 24 bits.
        script.push_back(write_row(CFG_TAIL_HI, 64'h0000_0000_0000_0018));
        script.push_back(known_row(abc_msg, 1'b0, abc_digest));
        script.push_back(write_row(CFG_PREFIX_TARGET, 64'hA999_3E36_4706_816A));
        script.push_back(known_row(abc_msg, 1'b1, abc_digest));
        // First word still matches, second is off by one bit.
        script.push_back(write_row(CFG_PREFIX_TARGET, 64'hA999_3E36_4706_816B));
        script.push_back(known_row(abc_msg, 1'b0, abc_digest));
        // Compare enable keeps only bit 0, so this turns the second word off.
        script.push_back(write_row(CFG_CHECK_SECOND, 64'hFFFF_FFFF_FFFF_FFFE));
        script.push_back(known_row(abc_msg, 1'b1, abc_digest));
        // Zero mask with zero target always hits.
        script.push_back(write_row(CFG_PREFIX_MASK, 64'h0));
        script.push_back(write_row(CFG_PREFIX_TARGET, 64'h0));
        script.push_back(known_row(abc_msg, 1'b1, abc_digest));
        // A target bit outside the mask can never match.
        script.push_back(write_row(CFG_PREFIX_TARGET, 64'h0000_0001_0000_0000));
        script.push_back(known_row(abc_msg, 1'b0, abc_digest));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_gap_pct    = 20;
        sink_stall_pct = 20;
        foreach (script[n]) begin
            if (script[n].kind == ROW_WRITE)
                write_register(script[n].index, script[n].data);
            else
                drive_candidate(script[n].cand, script[n].known, script[n].want);
        end

        // Random phases. Each starts with the core drained and every register
        // rewritten; one phase uses all ones, one all zeros. The last phase
        // runs with no idling on either side.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 1)
                flavor = SETUP_ONES;
            else if (p == 2)
                flavor = SETUP_ZERO;
            else
                flavor = SETUP_RANDOM;
            program_phase(flavor);
            if (p == PHASES - 1) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end else begin
                src_gap_pct    = random_idle_pct();
                sink_stall_pct = random_idle_pct();
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                drive_candidate(random_candidate(), 1'b0, unused);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (digest_errors == 0 && pending_digests.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
